FILE: design/rau_pkg.sv
package rau_pkg;

    localparam int OperandWidth = 32;
    localparam int ProdWidth    = 2 * OperandWidth;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_RED = 3'd5
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERODEN = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [61:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_out_word;

    // classified job passed from front to back
    typedef struct packed {
        t_opcode           opcode;
        logic              direct;   // result needs no reduction
        logic [1:0]        status;
        logic [1:0]        order;
        logic              neg;
        logic [62:0]       mag_num;
        logic [62:0]       mag_den;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CLASS,
        S_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GCD,
        B_DIVN,
        B_DIVD,
        B_DONE
    } t_back_state;

endpackage

FILE: design/rau_front.sv
module rau_front
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_word i_word,
    output logic     o_job_valid,
    input  logic     i_job_ready,
    output t_job     o_job
);

    t_front_state r_state, n_state;
    t_opcode      r_op;
    logic signed [OperandWidth-1:0] r_an, r_ad, r_bn, r_bd;
    logic [1:0]   r_stat;
    logic signed [ProdWidth-1:0] r_p0, r_p1, r_p2;
    t_job         r_job;

    function automatic logic signed [OperandWidth-1:0] sat(input logic signed [31:0] v);
        logic signed [OperandWidth-1:0] s;
        s = v[OperandWidth-1:0];
        if (s == {1'b1, {(OperandWidth-1){1'b0}}})
            s = {1'b1, {(OperandWidth-2){1'b0}}, 1'b1};
        return s;
    endfunction

    logic signed [OperandWidth-1:0] w_an, w_ad, w_bn, w_bd;
    logic [1:0] w_stat;
    always_comb begin
        w_an = sat(i_word.a_num);
        w_ad = sat(i_word.a_den);
        w_bn = sat(i_word.b_num);
        w_bd = sat(i_word.b_den);
        w_stat = ST_OK;
        if (i_word.opcode <= 3'd5) begin
            if (w_ad == '0 || (i_word.opcode != OP_RED && w_bd == '0))
                w_stat = ST_ZERODEN;
            else if (i_word.opcode == OP_DIV && w_bn == '0)
                w_stat = ST_DIVZERO;
        end
        if (w_ad < 0) begin
            w_ad = -w_ad;
            w_an = -w_an;
        end
        if (w_bd < 0) begin
            w_bd = -w_bd;
            w_bn = -w_bn;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_push) n_state = S_MUL;
            S_MUL:   n_state = S_CLASS;
            S_CLASS: n_state = S_PUSH;
            S_PUSH:  if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_full      = (r_state != S_IDLE);
        o_job_valid = (r_state == S_PUSH);
        o_job       = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // products: p0 = an*bd (or an*bn), p1 = bn*ad (or ad*bn), p2 = ad*bd
    logic signed [ProdWidth-1:0] w_num, w_den;
    logic w_direct;
    logic [1:0] w_ord;
    always_comb begin
        w_num = '0;
        w_den = 64'sd1;
        w_direct = 1'b0;
        w_ord = ORD_LESS;
        case (r_op)
            OP_ADD: begin w_num = r_p0 + r_p1; w_den = r_p2; end
            OP_SUB: begin w_num = r_p0 - r_p1; w_den = r_p2; end
            OP_MUL: begin w_num = r_p0; w_den = r_p2; end
            OP_DIV: begin w_num = r_p0; w_den = r_p1; end
            OP_RED: begin
                w_num = ProdWidth'(r_an);
                w_den = ProdWidth'(r_ad);
            end
            OP_CMP: begin
                w_direct = 1'b1;
                w_ord = (r_p0 < r_p1) ? ORD_LESS :
                        (r_p0 == r_p1) ? ORD_EQUAL : ORD_GREATER;
            end
            default: w_direct = 1'b1;
        endcase
        if (r_stat != ST_OK) begin
            w_direct = 1'b1;
            w_ord = ORD_LESS;
        end
        if (w_num == '0) w_direct = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_push) begin
            r_op   <= t_opcode'(i_word.opcode);
            r_an   <= w_an;
            r_ad   <= w_ad;
            r_bn   <= w_bn;
            r_bd   <= w_bd;
            r_stat <= w_stat;
        end
        if (r_state == S_MUL) begin
            r_p0 <= (r_op == OP_MUL) ? r_an * r_bn : r_an * r_bd;
            r_p1 <= (r_op == OP_DIV) ? r_ad * r_bn : r_bn * r_ad;
            r_p2 <= r_ad * r_bd;
        end
        if (r_state == S_CLASS) begin
            r_job.opcode  <= r_op;
            r_job.direct  <= w_direct;
            r_job.status  <= r_stat;
            r_job.order   <= w_ord;
            r_job.neg     <= w_num[ProdWidth-1] ^ w_den[ProdWidth-1];
            r_job.mag_num <= 63'(w_num[ProdWidth-1] ? -w_num : w_num);
            r_job.mag_den <= 63'(w_den[ProdWidth-1] ? -w_den : w_den);
        end
    end

endmodule

FILE: design/rau_fifo.sv
module rau_fifo
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_rd,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic w_wr, w_rd;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

FILE: design/rau_back.sv
module rau_back
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_take,
    input  t_job      i_job,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_word
);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [62:0] r_x, r_y, r_g;
    logic [5:0]  r_sh;
    logic [62:0] r_rem, r_quo, r_dvd;
    logic [5:0]  r_bit;
    logic [62:0] r_qn;
    t_out_word   r_out;

    logic w_div_last;
    assign w_div_last = (r_bit == 6'd0);

    // gcd loop ends once either operand reaches zero
    logic w_gcd_done;
    assign w_gcd_done = (r_x == '0) || (r_y == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (i_job_valid) n_state = i_job.direct ? B_DONE : B_GCD;
            B_GCD:  if (w_gcd_done) n_state = B_DIVN;
            B_DIVN: if (w_div_last) n_state = B_DIVD;
            B_DIVD: if (w_div_last) n_state = B_DONE;
            B_DONE: if (i_pop) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_take = (r_state == B_IDLE) && i_job_valid;
        o_empty    = (r_state != B_DONE);
        o_word     = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    // one restoring division bit per cycle
    logic [63:0] w_trial;
    logic [62:0] w_rem_sh;
    always_comb begin
        w_rem_sh = {r_rem[61:0], r_dvd[r_bit]};
        w_trial  = {1'b0, w_rem_sh} - {1'b0, r_g};
    end

    // binary gcd step: both even -> shift both; one even -> shift it; else subtract smaller from larger and halve
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_x   <= i_job.mag_num;
                r_y   <= i_job.mag_den;
                r_sh  <= '0;
            end
            B_GCD: begin
                if (w_gcd_done) begin
                    r_g   <= (r_x | r_y) << r_sh;
                    r_dvd <= r_job.mag_num;
                    r_rem <= '0;
                    r_bit <= 6'd62;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1; r_y <= r_y >> 1; r_sh <= r_sh + 6'd1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            B_DIVN, B_DIVD: begin
                r_rem <= w_trial[63] ? w_rem_sh : w_trial[62:0];
                r_quo <= {r_quo[61:0], ~w_trial[63]};
                r_bit <= r_bit - 6'd1;
                if (w_div_last && r_state == B_DIVN) begin
                    r_qn  <= {r_quo[61:0], ~w_trial[63]};
                    r_dvd <= r_job.mag_den;
                    r_rem <= '0;
                    r_bit <= 6'd62;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_job_valid && i_job.direct) begin
            r_out.res_num <= '0;
            r_out.res_den <= 62'd1;
            r_out.order   <= i_job.order;
            r_out.status  <= i_job.status;
        end
        if (r_state == B_DIVD && w_div_last) begin
            r_out.res_num <= r_job.neg ? -{1'b0, r_qn} : {1'b0, r_qn};
            r_out.res_den <= {r_quo[60:0], ~w_trial[63]};
            r_out.order   <= ORD_LESS;
            r_out.status  <= ST_OK;
        end
    end

endmodule

FILE: design/rational_arithmetic_unit_top.sv
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+---------------------------
// input    | i_word (opcode, a/b num, a/b den)   | word taken on push & !full
// result   | o_word (res_num, res_den, order,    | word taken on pop & !empty
//          |   status)                           |
//
// Front: latch + saturate/normalise, cross products, classify,
// hand-off to a two-entry job queue. Back: binary GCD, then two restoring
// divisions by the GCD; direct results (errors, compare, zero, unknown
// opcodes) skip straight to the output register.
// Reset (synchronous, i_rst_n low) clears handshake state only.
// Front may take and classify the next word while the back end is busy.
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);

    t_job w_fjob, w_bjob;
    logic w_fvalid, w_qready, w_qvalid, w_take;

    rau_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_word      (i_word),
        .o_job_valid (w_fvalid),
        .i_job_ready (w_qready),
        .o_job       (w_fjob)
    );

    rau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fvalid),
        .o_ready (w_qready),
        .i_job   (w_fjob),
        .o_valid (w_qvalid),
        .i_rd    (w_take),
        .o_job   (w_bjob)
    );

    rau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .o_job_take  (w_take),
        .i_job       (w_bjob),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (o_word)
    );

endmodule
